// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every edge outside reset.
`define ASRT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define ASRT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASRT_ALWAYS(label, clk, rst_n, expr)
`define ASRT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/tet_pkg.sv
// ---------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the timed event table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tet_pkg;

  localparam int TET_NUM_SLOTS = 8;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 8;
  localparam int SLOT_W        = 3;

  typedef enum logic [1:0] {
    MODE_SCHED  = 2'd0,
    MODE_CHECK  = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SCHED  = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  // Request token walking down the slot chain.
  typedef struct packed {
    logic              vld;
    mode_t             mode;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   id;
  } tok_t;

  // One result transaction.
  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

endpackage

// File: hdl/tet_cell.sv
// ---------------------------------------------------------------------------
// tet_cell
// One event slot; serves the token passing by and hands it on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tet_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  tet_pkg::tok_t tok_in,
  output tet_pkg::tok_t tok_out,
  output tet_pkg::res_t res
);
  import tet_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(IDX);

  logic              active_r, active_nxt;
  logic [TIME_W-1:0] trig_r, trig_nxt;
  logic [TIME_W-1:0] per_r, per_nxt;
  logic [ID_W-1:0]   ident_r, ident_nxt;
  tok_t              tok_r, tok_nxt;
  logic              kill;
  logic              due;

  assign due = active_r && (tok_in.now >= trig_r);

  always_comb begin
    active_nxt = active_r;
    trig_nxt   = trig_r;
    per_nxt    = per_r;
    ident_nxt  = ident_r;
    kill       = 1'b0;
    res        = '0;
    if (tok_in.vld) begin
      unique case (tok_in.mode)
        MODE_SCHED: begin
          if (!active_r) begin
            active_nxt = 1'b1;
            trig_nxt   = tok_in.now + tok_in.delay;
            per_nxt    = tok_in.period;
            ident_nxt  = tok_in.id;
            kill       = 1'b1;
            res        = '{vld: 1'b1, kind: KIND_SCHED, ok: 1'b1, id: tok_in.id,
                           slot: SLOT, last: 1'b1};
          end
        end
        MODE_CHECK: begin
          if (due) begin
            res = '{vld: 1'b1, kind: KIND_FIRED, ok: 1'b0, id: ident_r,
                    slot: SLOT, last: 1'b0};
            if (per_r != '0) trig_nxt = trig_r + per_r;
            else active_nxt = 1'b0;
          end
        end
        MODE_CANCEL: begin
          if (active_r && (ident_r == tok_in.id)) begin
            active_nxt = 1'b0;
            kill       = 1'b1;
            res        = '{vld: 1'b1, kind: KIND_CANCEL, ok: 1'b1, id: tok_in.id,
                           slot: SLOT, last: 1'b1};
          end
        end
        default: ;  // never injected
      endcase
    end
    tok_nxt     = tok_in;
    tok_nxt.vld = tok_in.vld && !kill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (step) begin
      active_r <= active_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      trig_r  <= trig_nxt;
      per_r   <= per_nxt;
      ident_r <= ident_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: hdl/timed_event_table.sv
// ---------------------------------------------------------------------------
// timed_event_table
// Table of timed event slots with schedule, check and cancel requests.
// ---------------------------------------------------------------------------
// A request is accepted only while no earlier request is still in flight.
// It is parked in a head register and then walks a chain of NUM_SLOTS slot
// cells, one cell per clock, each cell checking and updating its own slot.
// A schedule stops at the first free slot, a cancel at the first active
// slot with the same id; a check visits every slot, emitting a fired
// transaction for each due slot, and the done marker is produced when the
// token falls off the end of the chain. The chain only moves while the
// output register can take a new transaction, so backpressure on
// out_ready stalls the token in place. Mode 3 requests are accepted and
// dropped with no transaction. Due test is a plain unsigned now >= trigger;
// trigger arithmetic wraps mod 2^32.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timed_event_table #(
  parameter int NUM_SLOTS = tet_pkg::TET_NUM_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [tet_pkg::TIME_W-1:0]  in_now,
  input  logic [tet_pkg::TIME_W-1:0]  in_delay,
  input  logic [tet_pkg::TIME_W-1:0]  in_period,
  input  logic [tet_pkg::ID_W-1:0]    in_event_id,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic                        out_ok,
  output logic [tet_pkg::ID_W-1:0]    out_fired_id,
  output logic [tet_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_last
);
  import tet_pkg::*;

  // chain[0] is the head register, chain[i+1] the token leaving cell i
  tok_t chain [NUM_SLOTS+1];
  res_t cell_res [NUM_SLOTS];

  tok_t head_r;
  logic busy_r;
  logic step;          // chain and output register advance together
  logic accept;
  mode_t in_mode_e;
  tok_t  tail;
  res_t  tail_res;
  res_t  res_all;
  res_t  out_r;
  logic  out_valid_r;
  logic [NUM_SLOTS:0] tok_vec;

  assign in_mode_e = mode_t'(in_mode);
  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign step      = !out_valid_r || out_ready;

  // -------- head register: takes the transaction, feeds cell 0 ---------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
      busy_r     <= 1'b0;
    end else begin
      if (accept && (in_mode_e != MODE_IGNORE)) begin
        head_r <= '{vld: 1'b1, mode: in_mode_e, now: in_now, delay: in_delay,
                    period: in_period, id: in_event_id};
        busy_r <= 1'b1;
      end else begin
        if (step) head_r.vld <= 1'b0;
        // final transaction of the request leaves: table free again
        if (step && res_all.vld && res_all.last) busy_r <= 1'b0;
      end
    end
  end

  assign chain[0] = head_r;

  // -------- slot chain ---------------------------------------------------
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    tet_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .res     (cell_res[i])
    );
  end

  // -------- end of chain: nothing hit, close out the request -------------
  assign tail = chain[NUM_SLOTS];

  always_comb begin
    tail_res = '0;
    if (tail.vld) begin
      unique case (tail.mode)
        MODE_SCHED:  tail_res = '{vld: 1'b1, kind: KIND_SCHED, ok: 1'b0,
                                  id: tail.id, slot: '0, last: 1'b1};
        MODE_CHECK:  tail_res = '{vld: 1'b1, kind: KIND_DONE, ok: 1'b0,
                                  id: '0, slot: '0, last: 1'b1};
        MODE_CANCEL: tail_res = '{vld: 1'b1, kind: KIND_CANCEL, ok: 1'b0,
                                  id: tail.id, slot: '0, last: 1'b1};
        default:     tail_res = '0;
      endcase
    end
  end

  // Only the stage holding the token drives a nonzero result, so OR merges.
  always_comb begin
    res_all = tail_res;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      res_all = res_t'(res_all | cell_res[i]);
    end
  end

  // -------- output register ---------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_all.vld;
      out_r       <= res_all;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_ok       = out_r.ok;
  assign out_fired_id = out_r.id;
  assign out_slot     = out_r.slot;
  assign out_last     = out_r.last;

  // -------- checks ---------------------------------------------------------
  always_comb begin
    for (int i = 0; i <= NUM_SLOTS; i++) tok_vec[i] = chain[i].vld;
  end

  // at most one request walks the chain
  `ASRT_ALWAYS(a_one_token, clk, rst_n, $onehot0(tok_vec))
  // busy exactly while a token is somewhere in the chain
  `ASRT_ALWAYS(a_busy_token, clk, rst_n, busy_r == (tok_vec != '0))
  // results are produced only on behalf of an accepted request
  `ASRT_IMPLIES(a_res_busy, clk, rst_n, step && res_all.vld, busy_r)

endmodule

// File: verif/tb_timed_event_table.sv
// ---------------------------------------------------------------------------
// tb_timed_event_table
// Self-checking bench for the timed event table: a directed opening (empty
// table, full table, wrap of the trigger sum, periodic advance, cancel that
// skips freed slots, unused mode), then about 280 random requests built
// mostly as a running clock with schedules, checks and cancels drawn from a
// small id pool, plus full-range noise. A behavioral copy of the table
// predicts every result transaction at request acceptance; the monitor
// compares results in order. Idle and stall rates change in three phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timed_event_table;
  import tet_pkg::*;

  localparam int NUM_SLOTS       = TET_NUM_SLOTS;
  localparam int RANDOM_REQUESTS = 280;
  localparam int ID_POOL_SIZE    = 12;
  localparam int LIMIT_CYCLES    = 600_000;
  localparam int MAX_REPORTS     = 40;

  // One request as queued for the driver. wait_drain makes the driver hold
  // the request back until every outstanding result has come out.
  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   id;
    logic              wait_drain;
  } request_t;

  typedef struct packed {
    kind_t             kind;
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_mode = 2'd0;
  logic [TIME_W-1:0]   in_now = '0;
  logic [TIME_W-1:0]   in_delay = '0;
  logic [TIME_W-1:0]   in_period = '0;
  logic [ID_W-1:0]     in_event_id = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_kind;
  logic                out_ok;
  logic [ID_W-1:0]     out_fired_id;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_last;

  timed_event_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_now       (in_now),
    .in_delay     (in_delay),
    .in_period    (in_period),
    .in_event_id  (in_event_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_ok       (out_ok),
    .out_fired_id (out_fired_id),
    .out_slot     (out_slot),
    .out_last     (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Behavioral copy of the slot table and the queue of results it predicts
  // -------------------------------------------------------------------------
  logic              ev_active  [NUM_SLOTS];
  logic [TIME_W-1:0] ev_trigger [NUM_SLOTS];
  logic [TIME_W-1:0] ev_period  [NUM_SLOTS];
  logic [ID_W-1:0]   ev_ident   [NUM_SLOTS];

  result_t  awaited_results[$];
  request_t pending_requests[$];

  int errors          = 0;
  int results_seen    = 0;
  int requests_issued = 0;
  int total_requests  = 0;
  int cycle_count     = 0;
  int n_sched = 0, n_sched_full = 0, n_check = 0, n_fired = 0;
  int n_cancel = 0, n_cancel_miss = 0, n_unused = 0;

  function automatic result_t make_result(kind_t kind, logic ok, logic [ID_W-1:0] id,
                                          int slot_idx, logic last);
    result_t r;
    r.kind = kind;
    r.ok   = ok;
    r.id   = id;
    r.slot = SLOT_W'(slot_idx);
    r.last = last;
    return r;
  endfunction

  // Applies one accepted request to the table copy and queues its results.
  function automatic void update_event_table(logic [1:0] mode, logic [TIME_W-1:0] now,
                                             logic [TIME_W-1:0] delay,
                                             logic [TIME_W-1:0] period,
                                             logic [ID_W-1:0] id);
    int hit;
    hit = -1;
    case (mode)
      MODE_SCHED: begin
        n_sched++;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && !ev_active[i]) hit = i;
        if (hit >= 0) begin
          ev_active[hit]  = 1'b1;
          ev_trigger[hit] = now + delay;   // wraps mod 2^32
          ev_period[hit]  = period;
          ev_ident[hit]   = id;
          awaited_results.push_back(make_result(KIND_SCHED, 1'b1, id, hit, 1'b1));
        end else begin
          n_sched_full++;
          awaited_results.push_back(make_result(KIND_SCHED, 1'b0, id, 0, 1'b1));
        end
      end
      MODE_CHECK: begin
        n_check++;
        // Plain unsigned due test; a wrapped trigger looks due early.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (ev_active[i] && now >= ev_trigger[i]) begin
            n_fired++;
            awaited_results.push_back(make_result(KIND_FIRED, 1'b0, ev_ident[i], i, 1'b0));
            if (ev_period[i] != '0) ev_trigger[i] = ev_trigger[i] + ev_period[i];
            else ev_active[i] = 1'b0;
          end
        end
        awaited_results.push_back(make_result(KIND_DONE, 1'b0, '0, 0, 1'b1));
      end
      MODE_CANCEL: begin
        n_cancel++;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && ev_active[i] && ev_ident[i] == id) hit = i;
        if (hit >= 0) begin
          ev_active[hit] = 1'b0;
          awaited_results.push_back(make_result(KIND_CANCEL, 1'b1, id, hit, 1'b1));
        end else begin
          n_cancel_miss++;
          awaited_results.push_back(make_result(KIND_CANCEL, 1'b0, id, 0, 1'b1));
        end
      end
      default: n_unused++;   // unused mode: no transaction, table untouched
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic void queue_request(logic [1:0] mode, logic [TIME_W-1:0] now,
                                        logic [TIME_W-1:0] delay,
                                        logic [TIME_W-1:0] period,
                                        logic [ID_W-1:0] id, logic wait_drain);
    request_t rq;
    rq.mode       = mode;
    rq.now        = now;
    rq.delay      = delay;
    rq.period     = period;
    rq.id         = id;
    rq.wait_drain = wait_drain;
    pending_requests.push_back(rq);
  endfunction

  // Three phases: sender idles 31% / receiver 67%, then swapped, then none.
  function automatic int phase_of_run();
    if (requests_issued * 3 < total_requests) return 0;
    if (requests_issued * 3 < total_requests * 2) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (phase_of_run())
      0: return 31;
      1: return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (phase_of_run())
      0: return 67;
      1: return 31;
      default: return 0;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Driver: presents queued requests, holds payload until accepted
  // -------------------------------------------------------------------------
  request_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) requests_issued++;
      // A drain request is only launched from a cycle with valid low, so the
      // results of the previous request are already in the awaited queue.
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct() &&
          !(pending_requests[0].wait_drain && (in_valid || awaited_results.size() != 0))) begin
        next_req = pending_requests.pop_front();
        in_valid    <= 1'b1;
        in_mode     <= next_req.mode;
        in_now      <= next_req.now;
        in_delay    <= next_req.delay;
        in_period   <= next_req.period;
        in_event_id <= next_req.id;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted request,
  // so a result can never be matched against its own edge's prediction.
  // -------------------------------------------------------------------------
  result_t got_res;
  result_t exp_res;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_res.kind = kind_t'(out_kind);
        got_res.ok   = out_ok;
        got_res.id   = out_fired_id;
        got_res.slot = out_slot;
        got_res.last = out_last;
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got kind %0d ok %0d id %0d slot %0d last %0d",
                     $time, got_res.kind, got_res.ok, got_res.id, got_res.slot, got_res.last);
        end else begin
          exp_res = awaited_results.pop_front();
          if (got_res.kind !== exp_res.kind || got_res.ok !== exp_res.ok ||
              got_res.id !== exp_res.id || got_res.slot !== exp_res.slot ||
              got_res.last !== exp_res.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: result mismatch, expected kind %0d ok %0d id %0d slot %0d last %0d, got kind %0d ok %0d id %0d slot %0d last %0d",
                       $time, exp_res.kind, exp_res.ok, exp_res.id, exp_res.slot, exp_res.last,
                       got_res.kind, got_res.ok, got_res.id, got_res.slot, got_res.last);
          end
        end
      end
      if (in_valid && in_ready)
        update_event_table(in_mode, in_now, in_delay, in_period, in_event_id);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: build stimulus, reset, run, drain, report
  // -------------------------------------------------------------------------
  logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
  logic [TIME_W-1:0] clock_ms;
  int                roll;
  logic              drain;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) ev_active[i] = 1'b0;
    for (int i = 0; i < ID_POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(0, 255));
    id_pool[0] = '0;
    id_pool[1] = '1;

    // Directed: empty table, then fill it with field extremes and a wrap.
    queue_request(MODE_CHECK,  '0, '1, '1, '1, 1'b0);            // nothing due
    queue_request(MODE_CANCEL, 32'd7, '0, '0, 8'h55, 1'b0);       // no match
    queue_request(MODE_SCHED,  '0, '0, '0, '0, 1'b0);             // slot 0, one-shot
    queue_request(MODE_SCHED,  '1, '1, '1, '1, 1'b0);             // sum wraps to max-1
    queue_request(MODE_SCHED,  32'hFFFF_FFF0, 32'h20, 32'd5, 8'h11, 1'b0); // wraps to 16
    queue_request(MODE_SCHED,  32'd100, 32'd50, '0, 8'h22, 1'b0);
    queue_request(MODE_SCHED,  32'd100, 32'd1000, '0, 8'h11, 1'b0);   // duplicate id
    queue_request(MODE_SCHED,  '0, 32'd500, 32'd250, 8'h33, 1'b0);
    queue_request(MODE_SCHED,  '0, 32'd500, 32'd250, 8'h44, 1'b0);
    queue_request(MODE_SCHED,  '0, 32'd500, 32'd250, 8'h66, 1'b0);
    queue_request(MODE_SCHED,  32'd5, 32'd5, 32'd5, 8'h77, 1'b0);     // table full
    queue_request(MODE_IGNORE, '1, '1, '1, '1, 1'b0);                 // unused mode
    queue_request(MODE_CHECK,  32'd149, '0, '0, '0, 1'b0);  // one-shot and wrapped periodic
    queue_request(MODE_CHECK,  32'd150, '0, '0, '0, 1'b0);  // exact equality is due
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h11, 1'b0);    // first of two matches
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h11, 1'b0);    // second match
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h11, 1'b0);    // freed slots skipped
    queue_request(MODE_CHECK,  '1, '0, '0, '0, 1'b1);       // several fire, period wraps
    queue_request(MODE_CHECK,  '1, '0, '0, '0, 1'b0);       // periodic fires again
    queue_request(MODE_SCHED,  32'd3, 32'd1, '0, 8'h88, 1'b0); // reuses lowest free slot
    queue_request(MODE_CANCEL, '0, '0, '0, 8'hFF, 1'b0);
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h33, 1'b0);
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h44, 1'b0);
    queue_request(MODE_CANCEL, '0, '0, '0, 8'h66, 1'b0);
    queue_request(MODE_CHECK,  32'd4, '0, '0, '0, 1'b0);

    // Random: a running clock with schedules, checks and pool cancels;
    // occasional jumps close to the top of the time range and some noise.
    clock_ms = TIME_W'($urandom_range(0, 1000));
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll  = $urandom_range(0, 99);
      drain = (n % 60 == 0);
      if (n % 90 == 45) clock_ms = 32'hFFFF_FE00 + TIME_W'($urandom_range(0, 255));
      if (roll < 8) begin
        queue_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      id_pool[$urandom_range(0, ID_POOL_SIZE - 1)], drain);
      end else if (roll < 45) begin
        queue_request(MODE_SCHED, clock_ms, TIME_W'($urandom_range(0, 300)),
                      ($urandom_range(0, 1) != 0) ? '0 : TIME_W'($urandom_range(1, 200)),
                      id_pool[$urandom_range(0, ID_POOL_SIZE - 1)], drain);
      end else if (roll < 80) begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 120));
        queue_request(MODE_CHECK, clock_ms, $urandom, $urandom,
                      ID_W'($urandom_range(0, 255)), drain);
      end else begin
        queue_request(MODE_CANCEL, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                                   : ID_W'($urandom_range(0, 255)), drain);
      end
    end
    total_requests = pending_requests.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so driver and monitor updates have settled.
    while (pending_requests.size() != 0 || in_valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4 * (NUM_SLOTS + 1)) @(negedge clk);

    $display("Ran %0d requests: %0d schedules (%0d on a full table), %0d checks, %0d cancels",
             total_requests, n_sched, n_sched_full, n_check, n_cancel);
    $display("  (%0d missed), %0d unused-mode; %0d results with %0d fired events, %0d errors",
             n_cancel_miss, n_unused, results_seen, n_fired, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
